[design/cges_pkg.sv]
`timescale 1ns / 1ps

package cges_pkg;

   localparam int MAX_BODIES_DEF = 16;

   localparam logic signed [31:0] STAR_POS_RST  = 32'sd0;
   localparam logic [31:0]        STAR_MASS_RST = 32'h0001_0000;
   localparam logic [15:0]        TIME_STEP_RST = 16'd655;

   localparam logic ACT_ADD  = 1'b0;
   localparam logic ACT_STEP = 1'b1;

   typedef enum logic [1:0] {
      CSR_STAR_X    = 2'd0,
      CSR_STAR_Y    = 2'd1,
      CSR_STAR_MASS = 2'd2,
      CSR_TIME_STEP = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_FULL    = 2'd1,
      ST_EMPTY   = 2'd2,
      ST_ON_STAR = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      DIV_Q1,
      DIV_G,
      DIV_AX,
      DIV_AY
   } div_op_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_READ,
      S_LOAD,
      S_SQ_H,
      S_SQ_K,
      S_SQ_SUM,
      S_SQRT,
      S_ROOT,
      S_DIV,
      S_DIV_END,
      S_MUL_GX,
      S_LD_AX,
      S_MUL_GY,
      S_LD_AY,
      S_MUL_DVX,
      S_MUL_DVY,
      S_MUL_DPX,
      S_MUL_DPY,
      S_FIN
   } state_type;

   // Clamp a wide signed sum into the signed 32-bit range.
   function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
      logic signed [31:0] r;
      if (v > 36'sd2147483647) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -36'sd2147483648) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

[design/cges_ram.sv]
`timescale 1ns / 1ps

module cges_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/central_gravity_euler_step.sv]
`timescale 1ns / 1ps
// Add word: one result in the cycle after acceptance; the block is ready again at once.
// Step word: results strobed one per body; a body on the star skips the divider.
// Per body the block runs one shared bit-serial divider four times (64 steps each),
// a 32-step square root and one shared 33x33 multiplier.
// Synchronous active-high reset empties the table and loads the register defaults.
// Results cannot be stalled: each is on the rsp_ ports for exactly one cycle.
module central_gravity_euler_step
   import cges_pkg::*;
#(
   parameter int MAX_BODIES = MAX_BODIES_DEF,
   localparam int SLOT_W = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1,
   localparam int CNT_W  = $clog2(MAX_BODIES + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic                     req_action,
   input  logic signed [31:0]       req_body_pos_x,
   input  logic signed [31:0]       req_body_pos_y,
   input  logic signed [31:0]       req_body_vel_x,
   input  logic signed [31:0]       req_body_vel_y,
   output logic                     rsp_valid,
   output logic [SLOT_W-1:0]        rsp_body_slot,
   output logic signed [31:0]       rsp_new_pos_x,
   output logic signed [31:0]       rsp_new_pos_y,
   output logic signed [31:0]       rsp_new_vel_x,
   output logic signed [31:0]       rsp_new_vel_y,
   output logic [1:0]               rsp_status,
   output logic                     rsp_last_of_run,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [1:0]               csr_index,
   input  logic [31:0]              csr_wdata
);

   // Sequencer state.
   state_type st_ff, st_in;

   // Configuration registers.
   logic signed [31:0] star_x_ff, star_y_ff;
   logic [31:0]        mass_ff;
   logic [15:0]        dt_ff;

   // Table occupancy and the slot being stepped.
   logic [CNT_W-1:0]  count_ff;
   logic [SLOT_W-1:0] slot_ff;

   // Working registers of the body in flight.
   logic signed [31:0] pos_x_ff, pos_y_ff, vel_x_ff, vel_y_ff;
   logic signed [32:0] dx_ff, dy_ff;
   logic [63:0]        prod_ff;
   logic [63:0]        acc_ff;
   logic [63:0]        sq_res_ff;
   logic [63:0]        sq_bit_ff;
   logic [32:0]        r_ff;
   logic               zero_ff;
   div_op_type         op_ff;
   logic [63:0]        num_ff;
   logic [33:0]        rem_ff;
   logic [5:0]         cnt_ff;
   logic [30:0]        g_ff;
   logic [32:0]        qx_ff, qy_ff;
   logic [32:0]        dvx_ff, dvy_ff;
   logic [31:0]        dpx_ff;

   // Result registers.
   logic               rsp_valid_ff;
   logic [SLOT_W-1:0]  rsp_slot_ff;
   logic signed [31:0] rsp_px_ff, rsp_py_ff, rsp_vx_ff, rsp_vy_ff;
   status_type         rsp_status_ff;
   logic               rsp_last_ff;

   // Body table: one row holds position and velocity of one body.
   logic              ram_we;
   logic [SLOT_W-1:0] ram_waddr;
   logic [127:0]      ram_wdata;
   logic [127:0]      ram_rdata;

   cges_ram #(
      .WIDTH (128),
      .DEPTH (MAX_BODIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (slot_ff),
      .rd_data (ram_rdata)
   );

   // Handshake decode.
   logic accept, table_full, table_empty, last_body;
   assign accept      = start && (st_ff == S_IDLE);
   assign table_full  = (count_ff == CNT_W'(MAX_BODIES));
   assign table_empty = (count_ff == '0);
   assign last_body   = ((CNT_W'(slot_ff) + CNT_W'(1)) == count_ff);

   // Magnitudes of the star offset. When either one reaches 2^31 the root is
   // taken of the halved offsets and doubled afterwards.
   logic [32:0] ax, ay;
   logic        big;
   logic [31:0] hx, hy;
   assign ax  = dx_ff[32] ? 33'(-dx_ff) : 33'(dx_ff);
   assign ay  = dy_ff[32] ? 33'(-dy_ff) : 33'(dy_ff);
   assign big = ax[32] | ax[31] | ay[32] | ay[31];
   assign hx  = big ? ax[32:1] : ax[31:0];
   assign hy  = big ? ay[32:1] : ay[31:0];

   logic [31:0] vmag_x, vmag_y;
   assign vmag_x = vel_x_ff[31] ? 32'(-vel_x_ff) : 32'(vel_x_ff);
   assign vmag_y = vel_y_ff[31] ? 32'(-vel_y_ff) : 32'(vel_y_ff);

   // Square root step: one result bit per cycle.
   logic [63:0] sq_trial;
   logic        sq_fit;
   assign sq_trial = sq_res_ff + sq_bit_ff;
   assign sq_fit   = (acc_ff >= sq_trial);

   logic [32:0] r_w;
   assign r_w = big ? {sq_res_ff[31:0], 1'b0} : {1'b0, sq_res_ff[31:0]};

   // Divider step: restoring, one quotient bit per cycle shifted into num_ff.
   logic [34:0] div_shift, div_diff;
   logic        div_fit;
   assign div_shift = {rem_ff, num_ff[63]};
   assign div_diff  = div_shift - {2'b00, r_ff};
   assign div_fit   = !div_diff[34];

   // Shared multiplier.
   logic [32:0] mul_a, mul_b;
   logic [65:0] mul_p;
   assign mul_p = mul_a * mul_b;

   // Final updates of the body.
   logic [31:0]        dpy;
   logic signed [35:0] sum_px, sum_py, sum_vx, sum_vy;
   logic               dx_pos, dy_pos;
   logic signed [31:0] new_px, new_py, new_vx, new_vy;
   assign dpy    = prod_ff[47:16];
   assign dx_pos = !dx_ff[32] && (dx_ff != '0);
   assign dy_pos = !dy_ff[32] && (dy_ff != '0);
   assign sum_px = 36'(pos_x_ff) + (vel_x_ff[31] ? -$signed({4'b0, dpx_ff})
                                                 : $signed({4'b0, dpx_ff}));
   assign sum_py = 36'(pos_y_ff) + (vel_y_ff[31] ? -$signed({4'b0, dpy})
                                                 : $signed({4'b0, dpy}));
   assign sum_vx = 36'(vel_x_ff) + (dx_pos ? -$signed({3'b0, dvx_ff})
                                           : $signed({3'b0, dvx_ff}));
   assign sum_vy = 36'(vel_y_ff) + (dy_pos ? -$signed({3'b0, dvy_ff})
                                           : $signed({3'b0, dvy_ff}));
   assign new_px = sat32(sum_px);
   assign new_py = sat32(sum_py);
   assign new_vx = sat32(sum_vx);
   assign new_vy = sat32(sum_vy);

   // Next state.
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         S_IDLE: begin
            if (accept && req_action == ACT_STEP && !table_empty) begin
               st_in = S_READ;
            end
         end
         S_READ:    st_in = S_LOAD;
         S_LOAD:    st_in = S_SQ_H;
         S_SQ_H:    st_in = S_SQ_K;
         S_SQ_K:    st_in = S_SQ_SUM;
         S_SQ_SUM:  st_in = S_SQRT;
         S_SQRT: begin
            if (cnt_ff == 6'd31) begin
               st_in = S_ROOT;
            end
         end
         S_ROOT:    st_in = (r_w == '0) ? S_MUL_DVX : S_DIV;
         S_DIV: begin
            if (cnt_ff == 6'd63) begin
               st_in = S_DIV_END;
            end
         end
         S_DIV_END: begin
            unique case (op_ff)
               DIV_Q1: st_in = S_DIV;
               DIV_G:  st_in = S_MUL_GX;
               DIV_AX: st_in = S_MUL_GY;
               DIV_AY: st_in = S_MUL_DVX;
               default: st_in = S_IDLE;
            endcase
         end
         S_MUL_GX:  st_in = S_LD_AX;
         S_LD_AX:   st_in = S_DIV;
         S_MUL_GY:  st_in = S_LD_AY;
         S_LD_AY:   st_in = S_DIV;
         S_MUL_DVX: st_in = S_MUL_DVY;
         S_MUL_DVY: st_in = S_MUL_DPX;
         S_MUL_DPX: st_in = S_MUL_DPY;
         S_MUL_DPY: st_in = S_FIN;
         S_FIN:     st_in = last_body ? S_IDLE : S_READ;
         default:   st_in = S_IDLE;
      endcase
   end

   // Multiplier operands and table write port.
   always_comb begin
      mul_a     = '0;
      mul_b     = '0;
      ram_we    = 1'b0;
      ram_waddr = slot_ff;
      ram_wdata = {new_px, new_py, new_vx, new_vy};
      unique case (st_ff)
         S_IDLE: begin
            ram_we    = accept && req_action == ACT_ADD && !table_full;
            ram_waddr = count_ff[SLOT_W-1:0];
            ram_wdata = {req_body_pos_x, req_body_pos_y, req_body_vel_x, req_body_vel_y};
         end
         S_SQ_H: begin
            mul_a = {1'b0, hx};
            mul_b = {1'b0, hx};
         end
         S_SQ_K: begin
            mul_a = {1'b0, hy};
            mul_b = {1'b0, hy};
         end
         S_MUL_GX: begin
            mul_a = {2'b00, g_ff};
            mul_b = ax;
         end
         S_MUL_GY: begin
            mul_a = {2'b00, g_ff};
            mul_b = ay;
         end
         S_MUL_DVX: begin
            mul_a = qx_ff;
            mul_b = {17'b0, dt_ff};
         end
         S_MUL_DVY: begin
            mul_a = qy_ff;
            mul_b = {17'b0, dt_ff};
         end
         S_MUL_DPX: begin
            mul_a = {1'b0, vmag_x};
            mul_b = {17'b0, dt_ff};
         end
         S_MUL_DPY: begin
            mul_a = {1'b0, vmag_y};
            mul_b = {17'b0, dt_ff};
         end
         S_FIN: begin
            ram_we = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= S_IDLE;
         count_ff     <= '0;
         slot_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         star_x_ff    <= STAR_POS_RST;
         star_y_ff    <= STAR_POS_RST;
         mass_ff      <= STAR_MASS_RST;
         dt_ff        <= TIME_STEP_RST;
      end else begin
         st_ff        <= st_in;
         rsp_valid_ff <= (accept && !(req_action == ACT_STEP && !table_empty))
                         || (st_ff == S_FIN);
         if (accept && req_action == ACT_ADD && !table_full) begin
            count_ff <= count_ff + CNT_W'(1);
         end
         if (accept) begin
            slot_ff <= '0;
         end else if (st_ff == S_FIN) begin
            slot_ff <= slot_ff + SLOT_W'(1);
         end
         if (csr_valid) begin
            unique case (csr_index_type'(csr_index))
               CSR_STAR_X:    star_x_ff <= csr_wdata;
               CSR_STAR_Y:    star_y_ff <= csr_wdata;
               CSR_STAR_MASS: mass_ff   <= csr_wdata;
               CSR_TIME_STEP: dt_ff     <= csr_wdata[15:0];
               default: begin
               end
            endcase
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      unique case (st_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_last_ff <= 1'b1;
               if (req_action == ACT_ADD && !table_full) begin
                  rsp_slot_ff   <= count_ff[SLOT_W-1:0];
                  rsp_px_ff     <= req_body_pos_x;
                  rsp_py_ff     <= req_body_pos_y;
                  rsp_vx_ff     <= req_body_vel_x;
                  rsp_vy_ff     <= req_body_vel_y;
                  rsp_status_ff <= ST_OK;
               end else begin
                  rsp_slot_ff   <= '0;
                  rsp_px_ff     <= '0;
                  rsp_py_ff     <= '0;
                  rsp_vx_ff     <= '0;
                  rsp_vy_ff     <= '0;
                  rsp_status_ff <= (req_action == ACT_ADD) ? ST_FULL : ST_EMPTY;
               end
            end
         end
         S_LOAD: begin
            pos_x_ff <= ram_rdata[127:96];
            pos_y_ff <= ram_rdata[95:64];
            vel_x_ff <= ram_rdata[63:32];
            vel_y_ff <= ram_rdata[31:0];
            dx_ff    <= 33'($signed(ram_rdata[127:96])) - 33'(star_x_ff);
            dy_ff    <= 33'($signed(ram_rdata[95:64])) - 33'(star_y_ff);
         end
         S_SQ_H: begin
            prod_ff <= mul_p[63:0];
         end
         S_SQ_K: begin
            acc_ff  <= prod_ff;
            prod_ff <= mul_p[63:0];
         end
         S_SQ_SUM: begin
            acc_ff    <= acc_ff + prod_ff;
            sq_res_ff <= '0;
            sq_bit_ff <= 64'h4000_0000_0000_0000;
            cnt_ff    <= '0;
         end
         S_SQRT: begin
            if (sq_fit) begin
               acc_ff    <= acc_ff - sq_trial;
               sq_res_ff <= (sq_res_ff >> 1) + sq_bit_ff;
            end else begin
               sq_res_ff <= sq_res_ff >> 1;
            end
            sq_bit_ff <= sq_bit_ff >> 2;
            cnt_ff    <= cnt_ff + 6'd1;
         end
         S_ROOT: begin
            r_ff    <= r_w;
            zero_ff <= (r_w == '0);
            qx_ff   <= '0;
            qy_ff   <= '0;
            num_ff  <= {mass_ff, 32'b0};
            rem_ff  <= '0;
            op_ff   <= DIV_Q1;
            cnt_ff  <= '0;
         end
         S_DIV: begin
            if (div_fit) begin
               rem_ff <= div_diff[33:0];
            end else begin
               rem_ff <= div_shift[33:0];
            end
            num_ff <= {num_ff[62:0], div_fit};
            cnt_ff <= cnt_ff + 6'd1;
         end
         S_DIV_END: begin
            rem_ff <= '0;
            cnt_ff <= '0;
            unique case (op_ff)
               DIV_Q1: op_ff <= DIV_G;
               DIV_G: begin
                  g_ff <= (num_ff > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : num_ff[30:0];
               end
               DIV_AX:  qx_ff <= num_ff[32:0];
               DIV_AY:  qy_ff <= num_ff[32:0];
               default: begin
               end
            endcase
         end
         S_MUL_GX, S_MUL_GY: begin
            prod_ff <= mul_p[63:0];
         end
         S_LD_AX: begin
            num_ff <= prod_ff;
            rem_ff <= '0;
            op_ff  <= DIV_AX;
            cnt_ff <= '0;
         end
         S_LD_AY: begin
            num_ff <= prod_ff;
            rem_ff <= '0;
            op_ff  <= DIV_AY;
            cnt_ff <= '0;
         end
         S_MUL_DVX: begin
            prod_ff <= mul_p[63:0];
         end
         S_MUL_DVY: begin
            dvx_ff  <= prod_ff[48:16];
            prod_ff <= mul_p[63:0];
         end
         S_MUL_DPX: begin
            dvy_ff  <= prod_ff[48:16];
            prod_ff <= mul_p[63:0];
         end
         S_MUL_DPY: begin
            dpx_ff  <= prod_ff[47:16];
            prod_ff <= mul_p[63:0];
         end
         S_FIN: begin
            rsp_slot_ff   <= slot_ff;
            rsp_px_ff     <= new_px;
            rsp_py_ff     <= new_py;
            rsp_vx_ff     <= new_vx;
            rsp_vy_ff     <= new_vy;
            rsp_status_ff <= zero_ff ? ST_ON_STAR : ST_OK;
            rsp_last_ff   <= last_body;
         end
         default: begin
         end
      endcase
   end

   assign busy            = (st_ff != S_IDLE);
   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_body_slot   = rsp_slot_ff;
   assign rsp_new_pos_x   = rsp_px_ff;
   assign rsp_new_pos_y   = rsp_py_ff;
   assign rsp_new_vel_x   = rsp_vx_ff;
   assign rsp_new_vel_y   = rsp_vy_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_last_of_run = rsp_last_ff;

endmodule
